// ===== rtl/pfa_pkg.sv =====
// Shared constants and word types of the page frame allocator.
`default_nettype none

package pfa_pkg;

    // Geometry of a frame and of the address words
    localparam int PFA_FRAME_BYTES  = 4096;
    localparam int PFA_FRAME_SHIFT  = $clog2(PFA_FRAME_BYTES);
    localparam int PFA_ADDR_W       = 52;
    localparam int PFA_FRAME_W      = PFA_ADDR_W - PFA_FRAME_SHIFT;
    localparam int PFA_INDEX_W      = 42;
    localparam int PFA_REG_W        = 40;

    // Region register slots and parameter defaults
    localparam int PFA_REG_SLOTS    = 4;
    localparam int PFA_SLOT_W       = $clog2(PFA_REG_SLOTS);
    localparam int PFA_CFG_INDEX_W  = PFA_SLOT_W + 1;
    localparam int PFA_REGION_COUNT = 4;
    localparam int PFA_FREE_DEPTH   = 1024;

    // Low bit of a register index picks base or frame count
    localparam logic PFA_CFG_SEL_BASE   = 1'b0;
    localparam logic PFA_CFG_SEL_FRAMES = 1'b1;

    // Request operations
    localparam logic PFA_OP_ALLOC = 1'b0;
    localparam logic PFA_OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] PFA_ST_ALLOCATED = 2'd0;
    localparam logic [1:0] PFA_ST_NO_MEMORY = 2'd1;
    localparam logic [1:0] PFA_ST_FREED     = 2'd2;
    localparam logic [1:0] PFA_ST_DROPPED   = 2'd3;

    typedef struct packed {
        logic                  operation;
        logic [PFA_ADDR_W-1:0] free_address;
    } pfa_request_t;

    typedef struct packed {
        logic [PFA_ADDR_W-1:0] frame_address;
        logic [1:0]            status;
    } pfa_result_t;

endpackage

`default_nettype wire

// ===== rtl/page_frame_allocator_top.sv =====
// Page frame allocator: region bump allocation with a LIFO store of freed frames.
`default_nettype none

// A word is taken on start while busy is low. A free request is handled in the
// idle state: done pulses in the cycle after acceptance. An allocate request runs
// through a sequencer around one shared 42-bit add/subtract unit: it sums the
// frame counts of the active regions (one region a cycle), compares the running
// index with that total, then walks the regions (one a cycle) and forms the
// frame address. With at most four active regions, a hit yields the region base
// plus the remaining offset; when the index is at or past the total, a frame is
// popped from the freed store through its registered memory read, and if the
// store is empty an out-of-memory reply is given.
// Each result is marked by done for exactly one cycle, and must be taken then:
// there is no back-pressure. The configuration port is always ready and must only
// be written while the block is idle.
module page_frame_allocator_top
    import pfa_pkg::*;
#(
    parameter int REGION_COUNT = PFA_REGION_COUNT,
    parameter int FREE_DEPTH   = PFA_FREE_DEPTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire pfa_request_t               request,
    output logic                            busy,
    output logic                            done,
    output pfa_result_t                     result,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [PFA_CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [PFA_REG_W-1:0]       cfg_data
);

    localparam int ACTIVE  = (REGION_COUNT < PFA_REG_SLOTS) ? REGION_COUNT : PFA_REG_SLOTS;
    localparam int COUNT_W = $clog2(FREE_DEPTH + 1);
    localparam int MEM_AW  = $clog2(FREE_DEPTH);
    localparam logic [PFA_SLOT_W-1:0] LAST_REGION = PFA_SLOT_W'(ACTIVE - 1);
    localparam logic [COUNT_W-1:0]    DEPTH_FULL  = COUNT_W'(FREE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SUM   = 6'b000010,
        S_CHECK = 6'b000100,
        S_WALK  = 6'b001000,
        S_ADDR  = 6'b010000,
        S_POP   = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [PFA_REG_W-1:0]     base_reg   [PFA_REG_SLOTS];
    logic [PFA_REG_W-1:0]     frames_reg [PFA_REG_SLOTS];
    logic [PFA_INDEX_W-1:0]   index_reg, index_next;
    logic [PFA_INDEX_W-1:0]   acc_reg, acc_next;
    logic [PFA_INDEX_W-1:0]   offset_reg, offset_next;
    logic [PFA_SLOT_W-1:0]    slot_reg, slot_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     done_reg, done_next;
    pfa_result_t              result_reg, result_next;

    // Freed frame store and its registered read port
    logic [PFA_FRAME_W-1:0]   freed_mem [FREE_DEPTH];
    logic [PFA_FRAME_W-1:0]   rd_data_reg;
    logic                     mem_we, mem_re;
    logic [MEM_AW-1:0]        wr_addr, rd_addr;
    logic [COUNT_W-1:0]       count_dec;
    logic [PFA_FRAME_W-1:0]   push_frame;

    // Shared add/subtract unit
    logic [PFA_INDEX_W-1:0]   alu_a, alu_b;
    logic                     alu_sub;
    logic [PFA_INDEX_W:0]     alu_sum;
    logic                     alu_carry;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign count_dec  = count_reg - COUNT_W'(1);
    assign wr_addr    = count_reg[MEM_AW-1:0];
    assign rd_addr    = count_dec[MEM_AW-1:0];
    assign push_frame = request.free_address[PFA_ADDR_W-1:PFA_FRAME_SHIFT];

    // Pick operands for the shared unit by state
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = {2'b00, frames_reg[slot_reg]};
        alu_sub = 1'b0;
        case (state_reg)
            S_SUM:
            begin
                alu_a   = acc_reg;
                alu_b   = {2'b00, frames_reg[slot_reg]};
                alu_sub = 1'b0;
            end
            S_CHECK:
            begin
                alu_a   = index_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            S_WALK:
            begin
                alu_a   = offset_reg;
                alu_b   = {2'b00, frames_reg[slot_reg]};
                alu_sub = 1'b1;
            end
            S_ADDR:
            begin
                alu_a   = offset_reg;
                alu_b   = {2'b00, base_reg[slot_reg]};
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = acc_reg;
                alu_b   = {2'b00, frames_reg[slot_reg]};
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (PFA_INDEX_W + 1)'(alu_sub);
    assign alu_carry = alu_sum[PFA_INDEX_W];

    // Sequence one request
    always_comb
    begin
        state_next  = state_reg;
        index_next  = index_reg;
        acc_next    = acc_reg;
        offset_next = offset_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (request.operation == PFA_OP_FREE)
                    begin
                        result_next.frame_address = '0;
                        done_next                 = 1'b1;
                        if (count_reg < DEPTH_FULL)
                        begin
                            mem_we             = 1'b1;
                            count_next         = count_reg + COUNT_W'(1);
                            result_next.status = PFA_ST_FREED;
                        end
                        else
                        begin
                            result_next.status = PFA_ST_DROPPED;
                        end
                    end
                    else
                    begin
                        acc_next   = '0;
                        slot_next  = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                // accumulate the frame count of one region
                acc_next = alu_sum[PFA_INDEX_W-1:0];
                if (slot_reg == LAST_REGION)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    slot_next = slot_reg + PFA_SLOT_W'(1);
                end
            end
            S_CHECK:
            begin
                // index below total: walk the regions, else fall back to the store
                slot_next   = '0;
                offset_next = index_reg;
                if (!alu_carry)
                begin
                    state_next = S_WALK;
                end
                else if (count_reg != '0)
                begin
                    mem_re     = 1'b1;
                    count_next = count_dec;
                    state_next = S_POP;
                end
                else
                begin
                    result_next.frame_address = '0;
                    result_next.status        = PFA_ST_NO_MEMORY;
                    done_next                 = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            S_WALK:
            begin
                // offset below this region's count: hit, else step past it
                if (!alu_carry)
                begin
                    state_next = S_ADDR;
                end
                else
                begin
                    offset_next = alu_sum[PFA_INDEX_W-1:0];
                    slot_next   = slot_reg + PFA_SLOT_W'(1);
                end
            end
            S_ADDR:
            begin
                result_next.frame_address = {alu_sum[PFA_FRAME_W-1:0],
                                             {PFA_FRAME_SHIFT{1'b0}}};
                result_next.status        = PFA_ST_ALLOCATED;
                index_next                = index_reg + PFA_INDEX_W'(1);
                done_next                 = 1'b1;
                state_next                = S_IDLE;
            end
            S_POP:
            begin
                result_next.frame_address = {rd_data_reg, {PFA_FRAME_SHIFT{1'b0}}};
                result_next.status        = PFA_ST_ALLOCATED;
                done_next                 = 1'b1;
                state_next                = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            index_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            index_reg <= index_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Working registers of the sequencer
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        offset_reg <= offset_next;
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    // Region registers, written from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PFA_REG_SLOTS; i++)
            begin
                base_reg[i]   <= '0;
                frames_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index[0] == PFA_CFG_SEL_BASE)
            begin
                base_reg[cfg_index[PFA_CFG_INDEX_W-1:1]] <= cfg_data;
            end
            else
            begin
                frames_reg[cfg_index[PFA_CFG_INDEX_W-1:1]] <= cfg_data;
            end
        end
    end

    // Freed frame store: push on free, registered read on pop
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            freed_mem[wr_addr] <= push_frame;
        end
        if (mem_re)
        begin
            rd_data_reg <= freed_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the page frame allocator: regions, freed-frame store, configuration.
`timescale 1ns / 1ps

module tb_top;
    import pfa_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int MAX_GAP       = 14;
    localparam int PHASE_ITEMS   = 30;
    localparam int FULL_TAIL     = 40;
    localparam logic [PFA_REG_W-1:0] REG_MAX = '1;

    typedef enum {LAYOUT_WALK, LAYOUT_HUGE, LAYOUT_EMPTY} layout_t;

    // Running model of the allocator and the queue of results still owed
    class frame_ledger;
        logic [PFA_REG_W-1:0]   base_frame  [PFA_REG_SLOTS];
        logic [PFA_REG_W-1:0]   frame_count [PFA_REG_SLOTS];
        logic [PFA_INDEX_W-1:0] bump_index;
        logic [PFA_FRAME_W-1:0] freed_stack [PFA_FREE_DEPTH];
        int                     freed_depth;
        int                     active_regions;
        pfa_result_t            awaited_results[$];
        int                     errors;
        int                     accepted;
        int                     status_tally [4];

        function new(int regions);
            active_regions = (regions < PFA_REG_SLOTS) ? regions : PFA_REG_SLOTS;
            bump_index     = '0;
            freed_depth    = 0;
            errors         = 0;
            accepted       = 0;
            foreach (base_frame[r])
            begin
                base_frame[r]  = '0;
                frame_count[r] = '0;
            end
            foreach (status_tally[s])
                status_tally[s] = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch @%0t: %s", $realtime, msg);
        endtask

        function void write_reg(logic [PFA_CFG_INDEX_W-1:0] idx, logic [PFA_REG_W-1:0] data);
            if (idx[0] == PFA_CFG_SEL_BASE)
                base_frame[idx[PFA_CFG_INDEX_W-1:1]] = data;
            else
                frame_count[idx[PFA_CFG_INDEX_W-1:1]] = data;
        endfunction

        // Work out the result of one accepted request and advance the state
        function void note_request(pfa_request_t req);
            pfa_result_t            res;
            logic [PFA_INDEX_W-1:0] total;
            logic [PFA_INDEX_W-1:0] offset;
            logic [PFA_INDEX_W-1:0] frame_no;
            bit                     hit;
            res.frame_address = '0;
            res.status        = PFA_ST_NO_MEMORY;
            accepted++;
            if (req.operation == PFA_OP_ALLOC)
            begin
                total = '0;
                for (int i = 0; i < active_regions; i++)
                    total += frame_count[i];
                if (bump_index < total)
                begin
                    // walk the regions, stripping each one's count off the index
                    offset = bump_index;
                    hit    = 1'b0;
                    for (int i = 0; i < active_regions; i++)
                    begin
                        if (!hit && frame_count[i] > offset)
                        begin
                            frame_no          = base_frame[i] + offset;
                            res.frame_address = {frame_no[PFA_FRAME_W-1:0],
                                                 {PFA_FRAME_SHIFT{1'b0}}};
                            res.status        = PFA_ST_ALLOCATED;
                            bump_index        = bump_index + 1'b1;
                            hit               = 1'b1;
                        end
                        else if (!hit)
                        begin
                            offset -= frame_count[i];
                        end
                    end
                end
                else if (freed_depth > 0)
                begin
                    freed_depth--;
                    res.frame_address = {freed_stack[freed_depth], {PFA_FRAME_SHIFT{1'b0}}};
                    res.status        = PFA_ST_ALLOCATED;
                end
            end
            else
            begin
                if (freed_depth < PFA_FREE_DEPTH)
                begin
                    freed_stack[freed_depth] = req.free_address[PFA_ADDR_W-1:PFA_FRAME_SHIFT];
                    freed_depth++;
                    res.status = PFA_ST_FREED;
                end
                else
                begin
                    res.status = PFA_ST_DROPPED;
                end
            end
            awaited_results.push_back(res);
        endfunction

        task check_result(pfa_result_t got);
            pfa_result_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding: address %h status %0d",
                                 got.frame_address, got.status));
                return;
            end
            want = awaited_results.pop_front();
            status_tally[want.status]++;
            if (got.frame_address !== want.frame_address)
                report($sformatf("frame address %h, expected %h (status %0d)",
                                 got.frame_address, want.frame_address, want.status));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       start     = 1'b0;
    pfa_request_t               request   = '0;
    logic                       busy;
    logic                       done;
    pfa_result_t                result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [PFA_CFG_INDEX_W-1:0] cfg_index = '0;
    logic [PFA_REG_W-1:0]       cfg_data  = '0;

    logic [PFA_REG_W-1:0] cfg_base   [PFA_REG_SLOTS];
    logic [PFA_REG_W-1:0] cfg_frames [PFA_REG_SLOTS];
    layout_t              phase_plan [6] = '{LAYOUT_WALK, LAYOUT_HUGE, LAYOUT_WALK,
                                             LAYOUT_EMPTY, LAYOUT_WALK, LAYOUT_HUGE};
    bit                   steady_run     = 1'b0;
    int                   settings_count = 0;
    int unsigned          cycle_count    = 0;

    frame_ledger ledger = new(PFA_REGION_COUNT);

    page_frame_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Take every result word in the cycle it is strobed
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            ledger.check_result(result);
    end

    // Give up on a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [PFA_REG_W-1:0] random_reg();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[PFA_REG_W-1:0];
    endfunction

    function automatic pfa_request_t make_req(logic op, logic [PFA_ADDR_W-1:0] addr);
        pfa_request_t req;
        req.operation    = op;
        req.free_address = addr;
        return req;
    endfunction

    function automatic pfa_request_t random_req(int free_pct);
        logic [63:0] raw;
        logic        op;
        raw = {$urandom, $urandom};
        op  = ($urandom_range(0, 99) < free_pct) ? PFA_OP_FREE : PFA_OP_ALLOC;
        case ($urandom_range(0, 7))
            0:       return make_req(op, '0);
            1:       return make_req(op, '1);
            default: return make_req(op, raw[PFA_ADDR_W-1:0]);
        endcase
    endfunction

    // Present one request word after a random gap and hold it until taken
    task automatic issue(input pfa_request_t req);
        int gap;
        if ($urandom_range(0, 29) == 0)
            steady_run = !steady_run;
        gap = steady_run ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        ledger.note_request(req);
    endtask

    task automatic put_reg(input logic [PFA_CFG_INDEX_W-1:0] idx,
                           input logic [PFA_REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        ledger.write_reg(idx, data);
    endtask

    // Write all eight region registers from cfg_base and cfg_frames
    task automatic program_regions();
        logic [PFA_SLOT_W-1:0] slot;
        for (int r = 0; r < PFA_REG_SLOTS; r++)
        begin
            slot = PFA_SLOT_W'(r);
            put_reg({slot, PFA_CFG_SEL_BASE}, cfg_base[r]);
            put_reg({slot, PFA_CFG_SEL_FRAMES}, cfg_frames[r]);
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Drop start, wait for every owed result, then let the sequencer run dry
    task automatic settle();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (ledger.awaited_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic choose_layout(input layout_t kind);
        logic [PFA_INDEX_W-1:0] idx;
        int                     back;
        idx = ledger.bump_index;
        for (int r = 0; r < PFA_REG_SLOTS; r++)
        begin
            case (kind)
                LAYOUT_WALK:
                begin
                    case ($urandom_range(0, 3))
                        0:       cfg_base[r] = '0;
                        1:       cfg_base[r] = REG_MAX;
                        2:       cfg_base[r] = REG_MAX - 3;
                        default: cfg_base[r] = random_reg();
                    endcase
                    cfg_frames[r] = PFA_REG_W'($urandom_range(0, 6));
                end
                LAYOUT_HUGE:
                begin
                    cfg_base[r]   = (r == 0) ? REG_MAX : random_reg();
                    cfg_frames[r] = REG_MAX;
                end
                default:
                begin
                    cfg_base[r]   = random_reg();
                    cfg_frames[r] = '0;
                end
            endcase
        end
        // park region 0 just under the running index so the walk reaches the later ones
        if (kind == LAYOUT_WALK)
        begin
            back = $urandom_range(0, 3);
            if (idx > PFA_INDEX_W'(back))
                cfg_frames[0] = PFA_REG_W'(idx - PFA_INDEX_W'(back));
            else
                cfg_frames[0] = '0;
        end
    endtask

    initial
    begin
        int      free_pct;
        layout_t kind;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Frame-zero region, a region that runs off the top of the address, an empty one
        cfg_base   = '{40'h0, 40'hFF_FFFF_FFFE, 40'h1_2345, 40'h7_0000};
        cfg_frames = '{40'd2, 40'd4, 40'd0, 40'd1};
        program_regions();
        issue(make_req(PFA_OP_ALLOC, '1));
        issue(make_req(PFA_OP_ALLOC, '0));
        repeat (4) issue(random_req(0));
        issue(make_req(PFA_OP_ALLOC, '0));
        issue(make_req(PFA_OP_ALLOC, '1));
        issue(make_req(PFA_OP_FREE, '0));
        issue(make_req(PFA_OP_FREE, '1));
        issue(make_req(PFA_OP_FREE, 52'h0_0123_4567_89AB));
        repeat (4) issue(make_req(PFA_OP_ALLOC, 52'h0_0000_0000_5000));
        settle();

        // Shrink the regions below the running index
        cfg_base   = '{REG_MAX, 40'h0, REG_MAX - 1, 40'h5};
        cfg_frames = '{40'd1, 40'd1, 40'd1, 40'd0};
        program_regions();
        issue(make_req(PFA_OP_ALLOC, '0));
        issue(make_req(PFA_OP_FREE, 52'h0_0000_0000_5000));
        issue(make_req(PFA_OP_ALLOC, '0));
        issue(make_req(PFA_OP_ALLOC, '0));
        settle();

        // Grow them again: the index resumes inside the last region
        cfg_frames[3] = 40'd8;
        program_regions();
        repeat (5) issue(make_req(PFA_OP_ALLOC, '1));
        settle();

        // Random phases over a range of region layouts
        foreach (phase_plan[p])
        begin
            kind = phase_plan[p];
            choose_layout(kind);
            program_regions();
            free_pct = (kind == LAYOUT_HUGE) ? 65 : (kind == LAYOUT_WALK) ? 45 : 50;
            repeat (PHASE_ITEMS) issue(random_req(free_pct));
            settle();
        end

        // Fill the freed store, then work it at the brim
        choose_layout(LAYOUT_EMPTY);
        program_regions();
        while (ledger.freed_depth < PFA_FREE_DEPTH)
            issue(random_req(100));
        repeat (FULL_TAIL) issue(random_req(60));
        settle();

        if (ledger.awaited_results.size() != 0)
            ledger.report($sformatf("%0d results never arrived",
                                    ledger.awaited_results.size()));
        $display("covered %0d requests across %0d region settings",
                 ledger.accepted, settings_count);
        $display("outcomes: %0d allocated, %0d out of memory, %0d freed, %0d dropped",
                 ledger.status_tally[PFA_ST_ALLOCATED], ledger.status_tally[PFA_ST_NO_MEMORY],
                 ledger.status_tally[PFA_ST_FREED], ledger.status_tally[PFA_ST_DROPPED]);
        if (ledger.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pfa_pkg.sv
rtl/page_frame_allocator_top.sv
tb/sv/tb_top.sv
